>>> rtl/core/nprle_pkg.sv
// Package for the nibble-paired run-length decoder.
// Holds the item codes, reset constants and the count-unit control structs.
// No dependencies.
package nprle_pkg;

   // input opcodes
   localparam logic OP_RUN = 1'b0;
   localparam logic OP_END = 1'b1;

   // result kinds
   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // frame status codes
   localparam logic FRAME_COMPLETE = 1'b0;
   localparam logic FRAME_SHORT    = 1'b1;

   localparam logic [15:0] FRAME_PIXELS_RESET = 16'd64000;
   localparam int          NIBBLE_BITS        = 4;
   localparam int          RUN_IDX_BITS       = 5;

   // sequencer -> count unit
   typedef struct packed {
      logic incr;
      logic clear;
   } cnt_cmd_type;

   // count unit -> sequencer
   typedef struct packed {
      logic        at_limit;
      logic        last_slot;
      logic        frame_short;
      logic [15:0] position;
   } cnt_stat_type;

endpackage

>>> rtl/core/nprle_if.sv
// Valid/ready channel interfaces of the run-length decoder.
// nprle_req_if carries input groups, nprle_rsp_if carries result beats.
// No dependencies.
interface nprle_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] run_counts;
   logic [7:0] first_value;
   logic [7:0] second_value;

   modport source (output valid, opcode, run_counts, first_value, second_value,
                   input ready);
   modport sink (input valid, opcode, run_counts, first_value, second_value,
                 output ready);
endinterface

interface nprle_rsp_if;
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic [7:0]  pixel_value;
   logic [15:0] pixel_position;
   logic        frame_status;
   logic        last_in_run;

   modport source (output valid, item_kind, pixel_value, pixel_position,
                   frame_status, last_in_run, input ready);
   modport sink (input valid, item_kind, pixel_value, pixel_position,
                 frame_status, last_in_run, output ready);
endinterface

>>> rtl/core/nibble_pair_rle_decoder_core.sv
// Nibble-paired run-length decoder, top level.
// Depends on nprle_pkg, nprle_if, nprle_seq and nprle_count.
//
// req_bus takes one group a beat: opcode run carries a count byte and two
// pixel values; the block emits (high nibble + 1) copies of first_value and
// then (low nibble + 1) copies of second_value on rsp_bus, one pixel a beat,
// numbered from the start of the frame. Output stops once the frame size in
// csr_wr_data (written with csr_wr_en while idle) is reached; later groups
// give no beat. Opcode end gives one status beat (pixel count and short flag)
// and clears the count. The last beat of each group carries last_in_run.
// An accepted group is registered and the run state then walks it into the
// result register; req_bus.ready stays low until the walk ends, so no new
// group is taken before the last is through. The single pixel counter unit
// advances one pixel a cycle while rsp_bus.ready does not stall the walk.
// When rsp_bus.ready is low the result register holds and the walk pauses.
// Reset clears the count, loads a frame size of 64000 and empties the
// result register.
module nibble_pair_rle_decoder_core
   import nprle_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   nprle_req_if.sink   req_bus,
   nprle_rsp_if.source rsp_bus,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   cnt_cmd_type  cnt_cmd;
   cnt_stat_type cnt_stat;

   // run sequencer and result register
   nprle_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .cmd     (cnt_cmd),
      .stat    (cnt_stat)
   );

   // shared pixel counter
   nprle_count #(
      .COUNT_BITS (COUNT_BITS)
   ) u_count (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cnt_cmd),
      .stat        (cnt_stat)
   );

endmodule

>>> rtl/core/nprle_count.sv
// Shared pixel counter of the decoder: frame size register, running count,
// limit compare and status. Depends on nprle_pkg.
module nprle_count
   import nprle_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data,
   input  cnt_cmd_type  cmd,
   output cnt_stat_type stat
);

   localparam int ExtBits = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [15:0]           frame_ff, frame_in;
   logic [ExtBits-1:0]    ext_count, ext_frame, ext_max, limit;
   logic [ExtBits:0]      count_plus;

   // frame size register
   always_comb begin
      frame_in = csr_wr_en ? csr_wr_data : frame_ff;
   end

   // running count
   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.incr) begin
         count_in = count_ff + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= FRAME_PIXELS_RESET;
         count_ff <= '0;
      end else begin
         frame_ff <= frame_in;
         count_ff <= count_in;
      end
   end

   // limit is the smaller of frame size and counter capacity
   assign ext_count  = ExtBits'(count_ff);
   assign ext_frame  = ExtBits'(frame_ff);
   assign ext_max    = ExtBits'({COUNT_BITS{1'b1}});
   assign limit      = (ext_frame < ext_max) ? ext_frame : ext_max;
   assign count_plus = (ExtBits+1)'(ext_count) + (ExtBits+1)'(1);

   always_comb begin
      stat.at_limit    = (ext_count >= limit);
      stat.last_slot   = (count_plus >= (ExtBits+1)'(limit));
      stat.frame_short = (ext_count != ext_frame);
      stat.position    = ext_count[15:0];
   end

endmodule

>>> rtl/core/nprle_seq.sv
// Run sequencer of the decoder: takes one group, walks its two runs one
// pixel a beat into the result register. Depends on nprle_pkg, nprle_if.
module nprle_seq
   import nprle_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   nprle_req_if.sink    req_bus,
   nprle_rsp_if.source  rsp_bus,
   output cnt_cmd_type  cmd,
   input  cnt_stat_type stat
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_STAT = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [7:0]              counts_ff, counts_in;
   logic [7:0]              first_ff, first_in;
   logic [7:0]              second_ff, second_in;
   logic [RUN_IDX_BITS-1:0] idx_ff, idx_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        kind_ff, kind_in;
   logic [7:0]  value_ff, value_in;
   logic [15:0] pos_ff, pos_in;
   logic        status_ff, status_in;
   logic        last_ff, last_in;

   logic [RUN_IDX_BITS-1:0] first_end, total_m1;
   logic                    slot_free, last_item, pix_last;

   // run geometry from the count byte
   assign first_end = RUN_IDX_BITS'(counts_ff[7:4]);
   assign total_m1  = RUN_IDX_BITS'(counts_ff[7:4]) + RUN_IDX_BITS'(counts_ff[3:0])
                      + RUN_IDX_BITS'(1);
   assign last_item = (idx_ff == total_m1);
   assign pix_last  = last_item | stat.last_slot;
   assign slot_free = ~rsp_valid_ff | rsp_bus.ready;

   assign req_bus.ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      counts_in    = counts_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      kind_in      = kind_ff;
      value_in     = value_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               counts_in = req_bus.run_counts;
               first_in  = req_bus.first_value;
               second_in = req_bus.second_value;
               idx_in    = '0;
               state_in  = (req_bus.opcode == OP_END) ? ST_STAT : ST_RUN;
            end
         end
         ST_RUN: begin
            if (slot_free) begin
               if (stat.at_limit) begin
                  // frame already full: group is dropped
                  state_in = ST_IDLE;
               end else begin
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_PIXEL;
                  value_in     = (idx_ff <= first_end) ? first_ff : second_ff;
                  pos_in       = stat.position;
                  status_in    = FRAME_COMPLETE;
                  last_in      = pix_last;
                  cmd.incr     = 1'b1;
                  idx_in       = idx_ff + RUN_IDX_BITS'(1);
                  if (pix_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_STAT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_STATUS;
               value_in     = '0;
               pos_in       = stat.position;
               status_in    = stat.frame_short ? FRAME_SHORT : FRAME_COMPLETE;
               last_in      = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // group and result payload
   always_ff @(posedge clock) begin
      counts_ff <= counts_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      idx_ff    <= idx_in;
      kind_ff   <= kind_in;
      value_ff  <= value_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.item_kind      = kind_ff;
   assign rsp_bus.pixel_value    = value_ff;
   assign rsp_bus.pixel_position = pos_ff;
   assign rsp_bus.frame_status   = status_ff;
   assign rsp_bus.last_in_run    = last_ff;

endmodule

>>> rtl/core/nprle_checker.sv
// Port-level checks for the run-length decoder, bound to the top level.
// Depends on nprle_pkg and nibble_pair_rle_decoder_core.
module nprle_checker
   import nprle_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_item_kind,
   input logic [7:0]  rsp_pixel_value,
   input logic [15:0] rsp_pixel_position,
   input logic        rsp_frame_status,
   input logic        rsp_last_in_run
);

   // stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item_kind)
         && $stable(rsp_pixel_value) && $stable(rsp_pixel_position)
         && $stable(rsp_last_in_run))
      else $error("result beat changed while stalled");

   // block is busy in the cycle after taking a group
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready held after accept");

   // status beat is always single, zero-valued and closes its item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == KIND_STATUS |->
         rsp_last_in_run && rsp_pixel_value == 8'd0)
      else $error("malformed status beat");

   // pixel beats carry no frame status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == KIND_PIXEL |-> rsp_frame_status == FRAME_COMPLETE)
      else $error("frame status set on pixel beat");

endmodule

bind nibble_pair_rle_decoder_core nprle_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_item_kind      (rsp_bus.item_kind),
   .rsp_pixel_value    (rsp_bus.pixel_value),
   .rsp_pixel_position (rsp_bus.pixel_position),
   .rsp_frame_status   (rsp_bus.frame_status),
   .rsp_last_in_run    (rsp_bus.last_in_run)
);

>>> tb/nibble_pair_rle_decoder_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for nibble_pair_rle_decoder_core.
// Uses nprle_pkg and the nprle_req_if / nprle_rsp_if channel interfaces.
// Directed table first, then random frames checked against a built-in decoder.
module nibble_pair_rle_decoder_core_test;
   import nprle_pkg::*;

   localparam int          COUNT_BITS    = 16;
   localparam int unsigned COUNT_MAX     = (1 << COUNT_BITS) - 1;
   localparam int          RANDOM_ITEMS  = 100;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          DRAIN_LIMIT   = 5000;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          SCRIPT_ROWS   = 22;

   // one input group
   typedef struct packed {
      logic       opcode;
      logic [7:0] run_counts;
      logic [7:0] first_value;
      logic [7:0] second_value;
   } group_type;

   // one result beat
   typedef struct packed {
      logic        item_kind;
      logic [7:0]  pixel_value;
      logic [15:0] pixel_position;
      logic        frame_status;
      logic        last_in_run;
   } beat_type;

   // directed table: plain group, end group with a typed status, or frame size write
   typedef enum logic [1:0] {ROW_GROUP, ROW_STATUS, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [15:0]  csr_value;
      group_type    grp;
      logic [15:0]  status_pos;
      logic         status_flag;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [15:0] csr_wr_data;

   nprle_req_if req_bus ();
   nprle_rsp_if rsp_bus ();

   nibble_pair_rle_decoder_core #(
      .COUNT_BITS (COUNT_BITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // decoder state mirrored by the testbench
   int unsigned frame_size;
   int unsigned pixels_done;
   beat_type    expected_beats[$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int burst_left     = 0;
   logic long_hold_go = 1'b0;

   script_row_type script [SCRIPT_ROWS] = '{
      '{ROW_STATUS, 16'd0,     '{OP_END, 8'h00, 8'h00, 8'h00}, 16'd0,  FRAME_SHORT},
      '{ROW_GROUP,  16'd0,     '{OP_RUN, 8'h00, 8'hff, 8'h00}, 16'd0,  FRAME_COMPLETE},
      '{ROW_GROUP,  16'd0,     '{OP_RUN, 8'hff, 8'h00, 8'hff}, 16'd0,  FRAME_COMPLETE},
      '{ROW_GROUP,  16'd0,     '{OP_RUN, 8'hf0, 8'ha5, 8'h5a}, 16'd0,  FRAME_COMPLETE},
      '{ROW_GROUP,  16'd0,     '{OP_RUN, 8'h0f, 8'h5a, 8'ha5}, 16'd0,  FRAME_COMPLETE},
      '{ROW_STATUS, 16'd0,     '{OP_END, 8'hff, 8'hff, 8'hff}, 16'd68, FRAME_SHORT},
      // one-pixel frame: fills on the first pixel, later groups dropped
      '{ROW_CSR,    16'd1,     '{OP_RUN, 8'h00, 8'h00, 8'h00}, 16'd0,  FRAME_COMPLETE},
      '{ROW_GROUP,  16'd0,     '{OP_RUN, 8'h33, 8'h12, 8'h34}, 16'd0,  FRAME_COMPLETE},
      '{ROW_GROUP,  16'd0,     '{OP_RUN, 8'h00, 8'h80, 8'h7f}, 16'd0,  FRAME_COMPLETE},
      '{ROW_STATUS, 16'd0,     '{OP_END, 8'h00, 8'h00, 8'h00}, 16'd1,  FRAME_COMPLETE},
      // zero frame size: nothing ever comes out, end reports complete
      '{ROW_CSR,    16'd0,     '{OP_RUN, 8'h00, 8'h00, 8'h00}, 16'd0,  FRAME_COMPLETE},
      '{ROW_GROUP,  16'd0,     '{OP_RUN, 8'h11, 8'hc3, 8'h3c}, 16'd0,  FRAME_COMPLETE},
      '{ROW_STATUS, 16'd0,     '{OP_END, 8'h00, 8'h00, 8'h00}, 16'd0,  FRAME_COMPLETE},
      // frame fills in the middle of the second group
      '{ROW_CSR,    16'd40,    '{OP_RUN, 8'h00, 8'h00, 8'h00}, 16'd0,  FRAME_COMPLETE},
      '{ROW_GROUP,  16'd0,     '{OP_RUN, 8'hff, 8'h01, 8'hfe}, 16'd0,  FRAME_COMPLETE},
      '{ROW_GROUP,  16'd0,     '{OP_RUN, 8'hff, 8'h7f, 8'h80}, 16'd0,  FRAME_COMPLETE},
      '{ROW_GROUP,  16'd0,     '{OP_RUN, 8'h00, 8'h44, 8'h55}, 16'd0,  FRAME_COMPLETE},
      '{ROW_STATUS, 16'd0,     '{OP_END, 8'h00, 8'h00, 8'h00}, 16'd40, FRAME_COMPLETE},
      // largest frame size
      '{ROW_CSR,    16'd65535, '{OP_RUN, 8'h00, 8'h00, 8'h00}, 16'd0,  FRAME_COMPLETE},
      '{ROW_GROUP,  16'd0,     '{OP_RUN, 8'hff, 8'h80, 8'h7f}, 16'd0,  FRAME_COMPLETE},
      '{ROW_STATUS, 16'd0,     '{OP_END, 8'h00, 8'h00, 8'h00}, 16'd32, FRAME_SHORT},
      '{ROW_STATUS, 16'd0,     '{OP_END, 8'h00, 8'h00, 8'h00}, 16'd0,  FRAME_SHORT}
   };

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h",
               cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // expand one accepted group into the pixel/status beats it should give
   task automatic predict_decode(input group_type g, output int produced);
      int unsigned limit;
      int unsigned run1;
      int unsigned run2;
      int unsigned i;
      beat_type b;
      produced = 0;
      limit = (frame_size < COUNT_MAX) ? frame_size : COUNT_MAX;
      if (g.opcode == OP_END) begin
         b.item_kind      = KIND_STATUS;
         b.pixel_value    = 8'h00;
         b.pixel_position = pixels_done[15:0];
         b.frame_status   = (pixels_done != frame_size) ? FRAME_SHORT : FRAME_COMPLETE;
         b.last_in_run    = 1'b1;
         expected_beats.push_back(b);
         pixels_done = 0;
         produced = 1;
      end else begin
         run1 = g.run_counts[7:4] + 1;
         run2 = g.run_counts[3:0] + 1;
         for (i = 0; i < run1 + run2 && pixels_done < limit; i++) begin
            b.item_kind      = KIND_PIXEL;
            b.pixel_value    = (i < run1) ? g.first_value : g.second_value;
            b.pixel_position = pixels_done[15:0];
            b.frame_status   = FRAME_COMPLETE;
            b.last_in_run    = 1'b0;
            expected_beats.push_back(b);
            pixels_done = (pixels_done + 1) & COUNT_MAX;
            produced++;
         end
         if (produced > 0)
            expected_beats[expected_beats.size() - 1].last_in_run = 1'b1;
      end
   endtask

   // offer one group in a burst/gap pattern, predict once it is taken
   task automatic send_group(input group_type g, output int produced);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= g.opcode;
      req_bus.run_counts   <= g.run_counts;
      req_bus.first_value  <= g.first_value;
      req_bus.second_value <= g.second_value;
      do @(posedge clock); while (!req_bus.ready);
      predict_decode(g, produced);
   endtask

   // stop offering and wait for every expected beat, plus the block's tail
   task automatic wait_drained();
      int waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      while (expected_beats.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame_size(input logic [15:0] value);
      wait_drained();
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      frame_size = value;
   endtask

   function automatic group_type random_group();
      group_type g;
      g.opcode       = ($urandom_range(0, 11) == 0) ? OP_END : OP_RUN;
      g.run_counts   = $urandom_range(0, 255);
      g.first_value  = $urandom_range(0, 255);
      g.second_value = $urandom_range(0, 255);
      return g;
   endfunction

   // result receiver: stall pattern of its own, plus one long hold-off
   int       hold_left       = 0;
   bit       long_hold_taken = 1'b0;
   int       pattern_left    = 0;
   bit [7:0] stall_bits      = 8'hff;
   bit [2:0] stall_idx       = 3'd0;

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (long_hold_go && !long_hold_taken) begin
         long_hold_taken = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(20, 80);
            case ($urandom_range(0, 3))
               0: stall_bits = 8'hff;
               1: stall_bits = $urandom_range(0, 255);
               2: stall_bits = 8'hee;
               default: stall_bits = 8'h11;
            endcase
         end
         pattern_left = pattern_left - 1;
         stall_idx = stall_idx + 1;
         rsp_bus.ready <= stall_bits[stall_idx];
      end
   end

   // compare every result beat with the oldest expectation
   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("beat with nothing expected, position", rsp_bus.pixel_position, 0);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_bus.item_kind !== want.item_kind)
               report_mismatch("item_kind", rsp_bus.item_kind, want.item_kind);
            if (rsp_bus.pixel_value !== want.pixel_value)
               report_mismatch("pixel_value", rsp_bus.pixel_value, want.pixel_value);
            if (rsp_bus.pixel_position !== want.pixel_position)
               report_mismatch("pixel_position", rsp_bus.pixel_position, want.pixel_position);
            if (rsp_bus.frame_status !== want.frame_status)
               report_mismatch("frame_status", rsp_bus.frame_status, want.frame_status);
            if (rsp_bus.last_in_run !== want.last_in_run)
               report_mismatch("last_in_run", rsp_bus.last_in_run, want.last_in_run);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int        row;
      int        produced;
      int        random_count;
      int        phase;
      int        groups_left;
      group_type g;
      beat_type  typed;

      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_wr_data          <= 16'd0;
      req_bus.valid        <= 1'b0;
      req_bus.opcode       <= OP_RUN;
      req_bus.run_counts   <= 8'h00;
      req_bus.first_value  <= 8'h00;
      req_bus.second_value <= 8'h00;
      frame_size  = FRAME_PIXELS_RESET;
      pixels_done = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (row = 0; row < SCRIPT_ROWS; row++) begin
         case (script[row].kind)
            ROW_CSR: write_frame_size(script[row].csr_value);
            ROW_STATUS: begin
               send_group(script[row].grp, produced);
               // status beat is known up front; it replaces the predicted one
               typed.item_kind      = KIND_STATUS;
               typed.pixel_value    = 8'h00;
               typed.pixel_position = script[row].status_pos;
               typed.frame_status   = script[row].status_flag;
               typed.last_in_run    = 1'b1;
               expected_beats[expected_beats.size() - 1] = typed;
            end
            default: send_group(script[row].grp, produced);
         endcase
      end

      // random frames, each under its own frame size
      random_count = 0;
      phase = 0;
      while (random_count < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0: write_frame_size($urandom_range(1, 8));
            1: write_frame_size($urandom_range(1000, 65535));
            default: write_frame_size($urandom_range(16, 300));
         endcase
         // receiver holds off while groups keep coming, so input backs up
         if (phase == 1)
            long_hold_go <= 1'b1;
         groups_left = $urandom_range(6, 24);
         while (groups_left != 0) begin
            if (phase == 3 && groups_left == 3)
               wait_drained();
            g = random_group();
            send_group(g, produced);
            random_count++;
            groups_left--;
         end
         g = random_group();
         g.opcode = OP_END;
         send_group(g, produced);
         random_count++;
         phase++;
      end

      wait_drained();
      if (expected_beats.size() != 0)
         report_mismatch("beats never delivered", expected_beats.size(), 0);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
